/* rtl/core/qau_pkg.sv */
// Package for the quaternion arithmetic unit: operation codes, request and
// response types, fixed-point widths and pipeline stage positions.
// Depends on nothing; imported by quaternion_arith_unit.
`default_nettype none

package qau_pkg;

  localparam int FRAC_BITS = 28;
  localparam int DW        = 32;

  // normalize datapath widths
  localparam int SQ_STEPS  = 32;              // one root bit per stage
  localparam int SRW       = 35;              // square-root remainder
  localparam int QW        = FRAC_BITS + 2;   // quotient bits, magnitude <= 2^F + 2
  localparam int NUMW      = DW + FRAC_BITS + 1;
  localparam int DRW       = 34;              // divider partial remainder
  localparam int R0W       = NUMW - QW;       // top of numerator, below divisor

  // positions in the shared side-data pipeline (index 0 = stage 2)
  localparam int IDX_SQR   = 1;
  localparam int IDX_T     = 2;
  localparam int IDX_SQ0   = 3;
  localparam int IDX_PREP  = IDX_SQ0 + SQ_STEPS;
  localparam int IDX_DV0   = IDX_PREP + 1;
  localparam int IDX_LAST  = IDX_DV0 + QW - 1;

  typedef enum logic [1:0] {
    OP_PROD = 2'd0,
    OP_NORM = 2'd1,
    OP_CONJ = 2'd2,
    OP_NONE = 2'd3
  } qau_op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } qau_req_t;

  typedef struct packed {
    logic signed [31:0] out_w;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
    logic               zero_norm;
  } qau_rsp_t;

  // data that rides along the long normalize pipeline
  typedef struct packed {
    logic                 norm;
    logic                 zn;
    logic                 sat;
    logic [3:0]           neg;
    logic [3:0][DW-1:0]   res;
    logic [3:0][DW-1:0]   v;
  } qau_side_t;

endpackage

`default_nettype wire

/* rtl/core/quaternion_arith_unit.sv */
// Quaternion arithmetic unit: Hamilton product, normalize and conjugate.
// Depends on qau_pkg for types, widths and stage positions.
`default_nettype none

// Fully pipelined quaternion unit in signed fixed point with FRAC_BITS
// fraction bits (Q3.28). One request can enter every clock cycle while
// in_stall_o is low, and results leave in request order. The latency is set
// by the normalize path: one stage per bit of the 32-bit square root and one
// stage per quotient bit of the four lane dividers. Product and conjugate
// requests travel the same pipeline so that order is kept. The whole pipeline
// advances together; when the output holds a result that is stalled, every
// stage holds and in_stall_o is raised. Operation 3 returns zeros with both
// flags clear.
module quaternion_arith_unit
  import qau_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire qau_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output qau_rsp_t      out_rsp_o
);

  localparam logic signed [65:0] RND    = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] MAX66  = 66'sd2147483647;
  localparam logic signed [65:0] MIN66  = -66'sd2147483648;

  logic en;

  // ---------------------------------------------------------------- stage 0
  logic     vld0_q;
  qau_req_t req0_q;

  // ---------------------------------------------------------------- stage 1
  logic signed [31:0]        a [4];
  logic signed [31:0]        b [4];
  logic [DW-1:0]             u_d [4];
  logic [DW-1:0]             m_d;
  logic [4:0]                p_d;
  logic [4:0]                k_d;
  logic [3:0][DW-1:0]        conj_d;
  logic                      csat_d;
  logic signed [32:0]        nx;

  logic                      vld1_q;
  logic [1:0]                op1_q;
  logic signed [63:0]        prod1_q [4][4];
  logic [3:0][DW-1:0]        u1_q;
  logic [4:0]                k1_q;
  logic                      zn1_q;
  logic [3:0]                neg1_q;
  logic [3:0][DW-1:0]        conj1_q;
  logic                      csat1_q;

  // ---------------------------------------------------------------- side pipe
  logic      vld_q  [IDX_LAST+1];
  qau_side_t side_q [IDX_LAST+1];
  qau_side_t side_d;

  // normalize datapath
  logic [63:0]        sq_q [4];
  logic [63:0]        t_q;
  logic [DW-1:0]      root_q [SQ_STEPS];
  logic [SRW-1:0]     srem_q [SQ_STEPS];
  logic [63:0]        tsh_q  [SQ_STEPS];
  logic [DRW-1:0]     drem_q [QW][4];
  logic [QW-1:0]      dlow_q [QW][4];
  logic [QW-1:0]      quo_q  [QW][4];
  logic [DW:0]        den_q  [QW+1];
  logic [DRW-1:0]     prem_q [4];
  logic [QW-1:0]      plow_q [4];

  // hold everything while a finished result waits
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else if (en) begin
      vld0_q <= in_valid_i;
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      req0_q <= in_req_i;
    end
  end

  // Stage 1: sixteen products, magnitudes, normalizing shift, conjugate.
  always_comb begin
    a[0] = req0_q.a_w; a[1] = req0_q.a_x; a[2] = req0_q.a_y; a[3] = req0_q.a_z;
    b[0] = req0_q.b_w; b[1] = req0_q.b_x; b[2] = req0_q.b_y; b[3] = req0_q.b_z;
    for (int i = 0; i < 4; i++) begin
      u_d[i] = a[i][31] ? DW'(-{a[i][31], a[i]}) : DW'(a[i]);
    end
    m_d = u_d[0];
    for (int i = 1; i < 4; i++) begin
      if (u_d[i] > m_d) m_d = u_d[i];
    end
    p_d = '0;
    for (int i = 0; i < DW; i++) begin
      if (m_d[i]) p_d = 5'(i);
    end
    k_d = (p_d >= 5'd30) ? 5'd0 : 5'd30 - p_d;
    conj_d[0] = req0_q.a_w;
    csat_d    = 1'b0;
    for (int i = 1; i < 4; i++) begin
      nx = -{a[i][31], a[i]};
      if (nx > 33'sd2147483647) begin
        conj_d[i] = 32'h7fff_ffff;
        csat_d    = 1'b1;
      end else begin
        conj_d[i] = nx[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= req0_q.operation;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod1_q[i][j] <= a[i] * b[j];
        end
        u1_q[i]   <= u_d[i];
        neg1_q[i] <= a[i][31];
      end
      k1_q    <= k_d;
      zn1_q   <= (m_d == '0);
      conj1_q <= conj_d;
      csat1_q <= csat_d;
    end
  end

  // round half up, drop fraction bits, clip to 32 bits
  function automatic logic [32:0] rnd_clip(input logic signed [65:0] s);
    logic signed [65:0] r;
    logic [32:0]        o;
    r = (s + RND) >>> FRAC_BITS;
    if (r > MAX66) begin
      o = {1'b1, 32'h7fff_ffff};
    end else if (r < MIN66) begin
      o = {1'b1, 32'h8000_0000};
    end else begin
      o = {1'b0, r[31:0]};
    end
    return o;
  endfunction

  // Stage 2: product sums, shift magnitudes, select per operation.
  always_comb begin
    logic signed [65:0] s [4];
    logic [32:0]        c [4];
    s[0] = 66'(prod1_q[0][0]) - 66'(prod1_q[1][1]) - 66'(prod1_q[2][2])
         - 66'(prod1_q[3][3]);
    s[1] = 66'(prod1_q[0][1]) + 66'(prod1_q[1][0]) + 66'(prod1_q[2][3])
         - 66'(prod1_q[3][2]);
    s[2] = 66'(prod1_q[0][2]) - 66'(prod1_q[1][3]) + 66'(prod1_q[2][0])
         + 66'(prod1_q[3][1]);
    s[3] = 66'(prod1_q[0][3]) + 66'(prod1_q[1][2]) - 66'(prod1_q[2][1])
         + 66'(prod1_q[3][0]);
    for (int i = 0; i < 4; i++) begin
      c[i] = rnd_clip(s[i]);
    end
    side_d      = '0;
    side_d.neg  = neg1_q;
    for (int i = 0; i < 4; i++) begin
      side_d.v[i] = u1_q[i] << k1_q;
    end
    case (qau_op_e'(op1_q))
      OP_PROD: begin
        for (int i = 0; i < 4; i++) begin
          side_d.res[i] = c[i][31:0];
        end
        side_d.sat = c[0][32] | c[1][32] | c[2][32] | c[3][32];
      end
      OP_NORM: begin
        side_d.norm = 1'b1;
        side_d.zn   = zn1_q;
      end
      OP_CONJ: begin
        side_d.res = conj1_q;
        side_d.sat = csat1_q;
      end
      default: begin
        side_d.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
    end
  end

  // advance valid bits and side data along the pipe
  for (genvar g = 1; g <= IDX_LAST; g++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_q[g-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[g] <= side_q[g-1];
      end
    end
  end

  // squares, then their sum over four
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= 64'(side_q[0].v[i]) * 64'(side_q[0].v[i]);
      end
      t_q <= 64'((66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]) + 66'(sq_q[3])) >> 2);
    end
  end

  // integer square root, one root bit per stage
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    logic [DW-1:0]  root_in;
    logic [SRW-1:0] rem_in;
    logic [63:0]    t_in;
    logic [SRW-1:0] sh;
    logic [SRW-1:0] trial;
    if (g == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign t_in    = t_q;
    end else begin : g_next
      assign root_in = root_q[g-1];
      assign rem_in  = srem_q[g-1];
      assign t_in    = tsh_q[g-1];
    end
    assign sh    = {rem_in[SRW-3:0], t_in[63:62]};
    assign trial = SRW'({root_in, 2'b01});
    always_ff @(posedge clk_i) begin
      if (en) begin
        tsh_q[g] <= t_in << 2;
        if (sh >= trial) begin
          srem_q[g] <= sh - trial;
          root_q[g] <= {root_in[DW-2:0], 1'b1};
        end else begin
          srem_q[g] <= sh;
          root_q[g] <= {root_in[DW-2:0], 1'b0};
        end
      end
    end
  end

  // set up numerators (v << F) + r over divisor 2r
  always_ff @(posedge clk_i) begin
    logic [NUMW-1:0] num;
    if (en) begin
      den_q[0] <= {root_q[SQ_STEPS-1], 1'b0};
      for (int i = 0; i < 4; i++) begin
        num = (NUMW'(side_q[IDX_PREP-1].v[i]) << FRAC_BITS)
            + NUMW'(root_q[SQ_STEPS-1]);
        prem_q[i] <= DRW'(num[NUMW-1:QW]);
        plow_q[i] <= num[QW-1:0];
      end
    end
  end

  // restoring division, one quotient bit per stage in each lane
  for (genvar g = 0; g < QW; g++) begin : g_div
    logic [DRW-1:0] rem_in [4];
    logic [QW-1:0]  low_in [4];
    logic [QW-1:0]  q_in   [4];
    logic [DRW-1:0] sh     [4];
    for (genvar l = 0; l < 4; l++) begin : g_lane
      if (g == 0) begin : g_first
        assign rem_in[l] = prem_q[l];
        assign low_in[l] = plow_q[l];
        assign q_in[l]   = '0;
      end else begin : g_next
        assign rem_in[l] = drem_q[g-1][l];
        assign low_in[l] = dlow_q[g-1][l];
        assign q_in[l]   = quo_q[g-1][l];
      end
      assign sh[l] = {rem_in[l][DRW-2:0], low_in[l][QW-1]};
      always_ff @(posedge clk_i) begin
        if (en) begin
          dlow_q[g][l] <= low_in[l] << 1;
          if (sh[l] >= DRW'(den_q[g])) begin
            drem_q[g][l] <= sh[l] - DRW'(den_q[g]);
            quo_q[g][l]  <= {q_in[l][QW-2:0], 1'b1};
          end else begin
            drem_q[g][l] <= sh[l];
            quo_q[g][l]  <= {q_in[l][QW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        den_q[g+1] <= den_q[g];
      end
    end
  end

  // output register: apply signs to normalized magnitudes, else pass the stored result
  qau_side_t          fin;
  logic [3:0][DW-1:0] res_d;
  qau_rsp_t           rsp_d;

  assign fin = side_q[IDX_LAST];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (fin.norm && !fin.zn) begin
        res_d[i] = fin.neg[i] ? -DW'(quo_q[QW-1][i]) : DW'(quo_q[QW-1][i]);
      end else begin
        res_d[i] = fin.res[i];
      end
    end
    rsp_d.out_w     = res_d[0];
    rsp_d.out_x     = res_d[1];
    rsp_d.out_y     = res_d[2];
    rsp_d.out_z     = res_d[3];
    rsp_d.saturated = fin.sat;
    rsp_d.zero_norm = fin.zn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_q[IDX_LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rsp_o <= rsp_d;
    end
  end

`ifndef SYNTHESIS
  a_zero_norm_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.zero_norm |->
      out_rsp_o.out_w == '0 && out_rsp_o.out_x == '0 &&
      out_rsp_o.out_y == '0 && out_rsp_o.out_z == '0)
    else $error("zero-norm result has nonzero components");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.saturated && out_rsp_o.zero_norm))
    else $error("saturated and zero_norm both set");

  a_root_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[IDX_PREP-1] && side_q[IDX_PREP-1].norm && !side_q[IDX_PREP-1].zn |->
      root_q[SQ_STEPS-1][DW-1:29] != '0)
    else $error("square root below range, divisor too small");

  a_quot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[IDX_LAST] && fin.norm && !fin.zn |->
      quo_q[QW-1][0] <= (QW'(1) << FRAC_BITS) + QW'(2))
    else $error("normalized magnitude exceeds one unit plus two");
`endif

endmodule

`default_nettype wire
